/* src/ppu_pkg.sv */
// Shared types, constants and helpers for the palette pixel unpacker.
`default_nettype none
package ppu_pkg;

  localparam int unsigned BPP_W     = 3;
  localparam int unsigned LW_W      = 13;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned PAL_DEPTH = 256;
  localparam int unsigned PAL_AW    = 8;
  localparam int unsigned COLOR_W   = 24;

  localparam logic [BPP_W-1:0] MODE_1BPP   = 3'd0;
  localparam logic [BPP_W-1:0] MODE_2BPP   = 3'd1;
  localparam logic [BPP_W-1:0] MODE_4BPP   = 3'd2;
  localparam logic [BPP_W-1:0] MODE_8BPP   = 3'd3;
  localparam logic [BPP_W-1:0] MODE_RGB565 = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_BPP_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 1'b1;

  localparam logic [BPP_W-1:0] BPP_MODE_RST   = MODE_RGB565;
  localparam logic [LW_W-1:0]  LINE_WIDTH_RST = 13'd240;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic                  func;
    logic                  line_start;
    logic [15:0]           pixel_data;
    logic [PAL_AW-1:0]     palette_index;
    logic [COLOR_W-1:0]    palette_color;
  } in_t;

  typedef struct packed {
    logic [31:0] argb;
    logic        last;
    logic        line_end;
  } out_t;

  typedef struct packed {
    logic        rgb16;
    logic        pal_valid;
    logic [15:0] word;
    logic        last;
    logic        line_end;
  } iss_t;

  function automatic logic [31:0] expand_565(input logic [15:0] w);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = {w[15:11], w[15:13]};
    g = {w[10:5], w[10:9]};
    b = {w[4:0], w[4:2]};
    return {ALPHA_OPAQUE, r, g, b};
  endfunction

  function automatic logic [31:0] expand_palette(input logic [COLOR_W-1:0] e);
    return {ALPHA_OPAQUE, e[7:0], e[15:8], e[23:16]};
  endfunction

endpackage
`default_nettype wire

/* src/palette_pixel_unpacker.sv */
// Top level of the scan-out pixel decoder: config registers, sequencer, palette, output.
//
// Input channel (in_valid_i/in_ready_o/in_data_i): one beat is a palette write
// (func set) or one data item: an RGB565 word or a frame byte of 1/2/4/8-bpp pixels.
// Output channel (out_valid_o/out_ready_i/out_data_o): one opaque ARGB8888 pixel
// per beat, with last on the final pixel of an item and line_end on the last
// visible column. Config: cfg_we_i writes bpp_mode (index 0) or line_width (1).
// The first pixel of an item passes the sequencer, the palette read stage and
// the output register. Throughput, while the read stage takes pixels: one item
// per cycle for 16-bpp, 8-bpp and palette writes; a sub-byte item holds the
// sequencer up to its last visible pixel, one pixel per cycle on the single read port.
// Reset: column zero, bpp_mode 4, line_width 240; per-entry flags make the whole
// palette read as zero at once, so no clearing pass follows reset.
// Stall: the output register and the palette read stage hold; the sequencer
// keeps accepting until both are full, then in_ready_o drops while a data item waits.
`default_nettype none
module palette_pixel_unpacker #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire ppu_pkg::in_t                  in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output ppu_pkg::out_t                      out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [ppu_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [ppu_pkg::CFG_W-1:0]     cfg_wdata_i
);

  logic [ppu_pkg::BPP_W-1:0]   bpp_mode_q;
  logic [ppu_pkg::LW_W-1:0]    line_width_q;

  logic                        iss_valid, iss_ready;
  ppu_pkg::iss_t               iss;
  logic                        ram_we, ram_re;
  logic [ppu_pkg::PAL_AW-1:0]  ram_waddr, ram_raddr;
  logic [ppu_pkg::COLOR_W-1:0] ram_wdata, ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_mode_q   <= ppu_pkg::BPP_MODE_RST;
      line_width_q <= ppu_pkg::LINE_WIDTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ppu_pkg::CFG_BPP_MODE:   bpp_mode_q   <= cfg_wdata_i[ppu_pkg::BPP_W-1:0];
        ppu_pkg::CFG_LINE_WIDTH: line_width_q <= cfg_wdata_i[ppu_pkg::LW_W-1:0];
        default: ;
      endcase
    end
  end

  ppu_seq #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .mode_i       (bpp_mode_q),
    .line_width_i (line_width_q),
    .iss_valid_o  (iss_valid),
    .iss_ready_i  (iss_ready),
    .iss_o        (iss),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr)
  );

  ppu_ram #(
    .WIDTH(ppu_pkg::COLOR_W),
    .DEPTH(ppu_pkg::PAL_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ppu_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .iss_valid_i (iss_valid),
    .iss_ready_o (iss_ready),
    .iss_i       (iss),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re)) else $error("palette write and read in one cycle");

  a_read_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> iss_ready) else $error("palette read issued while read stage holds");

  a_line_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.line_end |-> out_data_o.last)
    else $error("line end pixel not marked last");

  a_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.argb[31:24] == ppu_pkg::ALPHA_OPAQUE)
    else $error("output pixel not opaque");

endmodule
`default_nettype wire

/* src/ppu_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module ppu_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* src/ppu_seq.sv */
// Item sequencer: column tracking, pixel split and palette read/write issue.
`default_nettype none
module ppu_seq #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire ppu_pkg::in_t                in_data_i,
  input  wire logic [ppu_pkg::BPP_W-1:0]   mode_i,
  input  wire logic [ppu_pkg::LW_W-1:0]    line_width_i,
  output logic                             iss_valid_o,
  input  wire logic                        iss_ready_i,
  output ppu_pkg::iss_t                    iss_o,
  output logic                             ram_we_o,
  output logic [ppu_pkg::PAL_AW-1:0]       ram_waddr_o,
  output logic [ppu_pkg::COLOR_W-1:0]      ram_wdata_o,
  output logic                             ram_re_o,
  output logic [ppu_pkg::PAL_AW-1:0]       ram_raddr_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WW = (CW > ppu_pkg::LW_W) ? CW : ppu_pkg::LW_W;

  logic                           busy_q;
  ppu_pkg::in_t                   item_q;
  logic [7:0]                     byte_q, byte_d;
  logic [2:0]                     rem_q, rem_load;
  logic                           start_q;
  logic [CW-1:0]                  col_q, col_d;
  logic [ppu_pkg::PAL_DEPTH-1:0]  pal_vld_q;

  logic [WW-1:0]             lw_ext, max_ext;
  logic [CW-1:0]             width;
  logic [CW-1:0]             col_base, col_n;
  logic                      bad_mode, drop, is_data, fire, last, done, load;
  logic [ppu_pkg::PAL_AW-1:0] idx;

  assign lw_ext  = WW'(line_width_i);
  assign max_ext = WW'(MAX_WIDTH);
  assign width   = (lw_ext > max_ext) ? max_ext[CW-1:0] : lw_ext[CW-1:0];

  assign bad_mode = mode_i > ppu_pkg::MODE_RGB565;
  assign col_base = start_q ? '0 : col_q;
  assign col_n    = col_base + CW'(1);
  assign drop     = col_base >= width;
  assign is_data  = busy_q && !item_q.func && !bad_mode;

  assign iss_valid_o = is_data && !drop;
  assign fire        = iss_valid_o && iss_ready_i;
  assign last        = (rem_q == 3'd0) || (col_n >= width);

  assign done = busy_q && (item_q.func || bad_mode || drop || (iss_ready_i && last));
  assign in_ready_o = !busy_q || done;
  assign load = in_valid_i && in_ready_o;

  always_comb begin
    case (mode_i)
      ppu_pkg::MODE_1BPP: begin
        idx      = {7'd0, byte_q[7]};
        byte_d   = {byte_q[6:0], 1'b0};
        rem_load = 3'd7;
      end
      ppu_pkg::MODE_2BPP: begin
        idx      = {6'd0, byte_q[7:6]};
        byte_d   = {byte_q[5:0], 2'b0};
        rem_load = 3'd3;
      end
      ppu_pkg::MODE_4BPP: begin
        idx      = {4'd0, byte_q[7:4]};
        byte_d   = {byte_q[3:0], 4'b0};
        rem_load = 3'd1;
      end
      default: begin
        idx      = byte_q;
        byte_d   = byte_q;
        rem_load = 3'd0;
      end
    endcase
  end

  always_comb begin
    col_d = col_q;
    if (is_data && drop) begin
      col_d = col_base;
    end else if (fire) begin
      col_d = col_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      col_q     <= '0;
      pal_vld_q <= '0;
      start_q   <= 1'b0;
      rem_q     <= 3'd0;
    end else begin
      col_q <= col_d;
      if (busy_q && item_q.func) begin
        pal_vld_q[item_q.palette_index] <= 1'b1;
      end
      if (load) begin
        busy_q  <= 1'b1;
        start_q <= in_data_i.line_start;
        rem_q   <= rem_load;
      end else if (done) begin
        busy_q <= 1'b0;
      end else if (fire) begin
        start_q <= 1'b0;
        rem_q   <= rem_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_data_i;
      byte_q <= in_data_i.pixel_data[7:0];
    end else if (fire) begin
      byte_q <= byte_d;
    end
  end

  assign iss_o.rgb16     = mode_i == ppu_pkg::MODE_RGB565;
  assign iss_o.pal_valid = pal_vld_q[idx];
  assign iss_o.word      = item_q.pixel_data;
  assign iss_o.last      = last;
  assign iss_o.line_end  = col_n == width;

  assign ram_we_o    = busy_q && item_q.func;
  assign ram_waddr_o = item_q.palette_index;
  assign ram_wdata_o = item_q.palette_color;
  assign ram_re_o    = fire && (mode_i != ppu_pkg::MODE_RGB565);
  assign ram_raddr_o = idx;

endmodule
`default_nettype wire

/* src/ppu_out.sv */
// Palette read stage and output register with pixel formatting.
`default_nettype none
module ppu_out (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        iss_valid_i,
  output logic                             iss_ready_o,
  input  wire ppu_pkg::iss_t               iss_i,
  input  wire logic [ppu_pkg::COLOR_W-1:0] ram_rdata_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output ppu_pkg::out_t                    out_data_o
);

  logic          s1_valid_q;
  ppu_pkg::iss_t s1_q;
  logic          out_valid_q;
  ppu_pkg::out_t out_q, out_d;
  logic          s1_adv;

  assign s1_adv      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign iss_ready_o = !s1_valid_q || s1_adv;

  always_comb begin
    if (s1_q.rgb16) begin
      out_d.argb = ppu_pkg::expand_565(s1_q.word);
    end else if (s1_q.pal_valid) begin
      out_d.argb = ppu_pkg::expand_palette(ram_rdata_i);
    end else begin
      out_d.argb = {ppu_pkg::ALPHA_OPAQUE, 24'd0};
    end
    out_d.last     = s1_q.last;
    out_d.line_end = s1_q.line_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (iss_ready_o) begin
        s1_valid_q <= iss_valid_i;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (iss_valid_i && iss_ready_o) begin
      s1_q <= iss_i;
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

/* tb/palette_pixel_unpacker_test.sv */
// Self-checking testbench for the palette pixel unpacker: random and directed beats, scoreboard.
`timescale 1ns / 100ps
module palette_pixel_unpacker_test;

  localparam int unsigned MAX_W        = 4096;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned PRINT_CAP    = 100;
  localparam logic        FUNC_PIXEL   = 1'b0;
  localparam logic        FUNC_PAL_WR  = 1'b1;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready_o;
  ppu_pkg::in_t                  in_data = '0;
  logic                          out_valid_o;
  logic                          out_ready = 1'b0;
  ppu_pkg::out_t                 out_data_o;
  logic                          cfg_we = 1'b0;
  logic [ppu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ppu_pkg::CFG_W-1:0]     cfg_wdata = '0;

  palette_pixel_unpacker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  // shadow of the block state
  logic [ppu_pkg::COLOR_W-1:0] palette_shadow [ppu_pkg::PAL_DEPTH];
  logic [ppu_pkg::LW_W-1:0]    col_shadow;
  logic [ppu_pkg::BPP_W-1:0]   mode_shadow;
  logic [ppu_pkg::LW_W-1:0]    width_shadow;

  ppu_pkg::in_t  frame_q [$];
  ppu_pkg::out_t pixel_q [$];
  ppu_pkg::out_t want;
  bit            in_took = 1'b0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   rx_hold = 0;
  int unsigned   cycles = 0;
  int unsigned   errors = 0;
  int unsigned   beats_in = 0;
  int unsigned   pixels_checked = 0;
  int unsigned   cfg_writes = 0;

  always #5 clk_i = ~clk_i;

  task automatic report(input string msg);
    if (errors < PRINT_CAP) $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic [7:0] widen5(input logic [4:0] v);
    logic [7:0] w;
    w = 8'(v);
    return 8'((w << 3) | (w >> 2));
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    logic [7:0] w;
    w = 8'(v);
    return 8'((w << 2) | (w >> 4));
  endfunction

  task automatic predict_pixels(input ppu_pkg::in_t it);
    logic [31:0]                 px [8];
    logic [ppu_pkg::COLOR_W-1:0] e;
    logic [7:0]                  frame_byte;
    logic [ppu_pkg::LW_W-1:0]    lim;
    int unsigned                 npix;
    int unsigned                 bits;
    logic [ppu_pkg::PAL_AW-1:0]  idx;
    int unsigned                 k;
    int unsigned                 cnt;
    ppu_pkg::out_t               beat;
    ppu_pkg::out_t               beats [8];
    if (it.func == FUNC_PAL_WR) begin
      palette_shadow[it.palette_index] = it.palette_color;
      return;
    end
    if (mode_shadow > ppu_pkg::MODE_RGB565) return;
    if (it.line_start) col_shadow = '0;
    frame_byte = it.pixel_data[7:0];
    if (mode_shadow == ppu_pkg::MODE_RGB565) begin
      px[0] = {8'hFF, widen5(it.pixel_data[15:11]), widen6(it.pixel_data[10:5]),
               widen5(it.pixel_data[4:0])};
      npix = 1;
    end else begin
      bits = 1 << mode_shadow;
      npix = 8 / bits;
      for (k = 0; k < npix; k++) begin
        idx = ppu_pkg::PAL_AW'((32'(frame_byte) >> ((npix - 1 - k) * bits)) &
                               ((1 << bits) - 1));
        e = palette_shadow[idx];
        px[3'(k)] = {8'hFF, e[7:0], e[15:8], e[23:16]};
      end
    end
    lim = (width_shadow > MAX_W) ? ppu_pkg::LW_W'(MAX_W) : width_shadow;
    cnt = 0;
    for (k = 0; k < npix; k++) begin
      if (col_shadow < lim) begin
        col_shadow++;
        beat.argb = px[3'(k)];
        beat.last = 1'b0;
        beat.line_end = (col_shadow == lim);
        beats[3'(cnt)] = beat;
        cnt++;
      end
    end
    if (cnt > 0) beats[3'(cnt - 1)].last = 1'b1;
    for (k = 0; k < cnt; k++) pixel_q.push_back(beats[3'(k)]);
  endtask

  // driver: next beat at the falling edge once the current one is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_took)) begin
      in_took = 1'b0;
      if (frame_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= frame_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure, with an optional long hold
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on input beats, check output beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        in_took = 1'b1;
        beats_in++;
        predict_pixels(in_data);
      end
      if (out_valid_o && out_ready) begin
        if (pixel_q.size() == 0) begin
          report($sformatf("pixel %h with nothing expected", out_data_o.argb));
        end else begin
          want = pixel_q.pop_front();
          pixels_checked++;
          if (out_data_o.argb !== want.argb)
            report($sformatf("argb %h, want %h", out_data_o.argb, want.argb));
          if (out_data_o.last !== want.last)
            report($sformatf("last %b, want %b (argb %h)", out_data_o.last, want.last,
                             want.argb));
          if (out_data_o.line_end !== want.line_end)
            report($sformatf("line_end %b, want %b (argb %h)", out_data_o.line_end,
                             want.line_end, want.argb));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d pixels outstanding", cycles, pixel_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic ppu_pkg::in_t pix_item(input logic start, input logic [15:0] data);
    ppu_pkg::in_t it;
    it.func = FUNC_PIXEL;
    it.line_start = start;
    it.pixel_data = data;
    it.palette_index = ppu_pkg::PAL_AW'($urandom);
    it.palette_color = ppu_pkg::COLOR_W'($urandom);
    return it;
  endfunction

  function automatic ppu_pkg::in_t pal_item(input logic [ppu_pkg::PAL_AW-1:0] idx,
                                            input logic [ppu_pkg::COLOR_W-1:0] color);
    ppu_pkg::in_t it;
    it.func = FUNC_PAL_WR;
    it.line_start = 1'($urandom);
    it.pixel_data = 16'($urandom);
    it.palette_index = idx;
    it.palette_color = color;
    return it;
  endfunction

  function automatic ppu_pkg::in_t random_item(input bit first);
    if ($urandom_range(7) == 0)
      return pal_item(ppu_pkg::PAL_AW'($urandom), ppu_pkg::COLOR_W'($urandom));
    return pix_item(first || $urandom_range(9) == 0, 16'($urandom));
  endfunction

  task automatic write_reg(input logic [ppu_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= ppu_pkg::CFG_W'(val);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == ppu_pkg::CFG_BPP_MODE) mode_shadow = ppu_pkg::BPP_W'(val);
    else width_shadow = ppu_pkg::LW_W'(val);
    cfg_writes++;
  endtask

  task automatic set_idling(input int unsigned sel);
    case (sel)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
      default: begin send_idle_pct = 10; recv_stall_pct = 10; end
    endcase
  endtask

  task automatic wait_drained();
    while (frame_q.size() != 0 || in_valid || pixel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned p;
    int unsigned k;
    int unsigned n;
    int unsigned bpp;
    int unsigned width;
    for (k = 0; k < ppu_pkg::PAL_DEPTH; k++) palette_shadow[ppu_pkg::PAL_AW'(k)] = '0;
    col_shadow = '0;
    mode_shadow = ppu_pkg::BPP_MODE_RST;
    width_shadow = ppu_pkg::LINE_WIDTH_RST;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset configuration: RGB565 extremes and primaries, then palette writes
    frame_q.push_back(pix_item(1'b1, 16'h0000));
    frame_q.push_back(pix_item(1'b0, 16'hFFFF));
    frame_q.push_back(pix_item(1'b0, 16'hF800));
    frame_q.push_back(pix_item(1'b0, 16'h07E0));
    frame_q.push_back(pix_item(1'b0, 16'h001F));
    frame_q.push_back(pal_item(8'd0, 24'hFFFFFF));
    frame_q.push_back(pal_item(8'd255, 24'h563412));
    frame_q.push_back(pal_item(8'd1, 24'h0000FF));
    frame_q.push_back(pal_item(8'd2, 24'h00FF00));
    frame_q.push_back(pal_item(8'd3, 24'hFF0000));
    frame_q.push_back(pal_item(8'd15, 24'hA5C3E1));
    wait_drained();

    write_reg(ppu_pkg::CFG_BPP_MODE, ppu_pkg::MODE_8BPP);
    frame_q.push_back(pix_item(1'b0, 16'hFF00));
    frame_q.push_back(pix_item(1'b0, 16'h00FF));
    wait_drained();
    write_reg(ppu_pkg::CFG_BPP_MODE, ppu_pkg::MODE_1BPP);
    frame_q.push_back(pix_item(1'b0, 16'h00A5));
    wait_drained();
    write_reg(ppu_pkg::CFG_BPP_MODE, ppu_pkg::MODE_2BPP);
    frame_q.push_back(pix_item(1'b0, 16'hC41B));
    wait_drained();
    write_reg(ppu_pkg::CFG_BPP_MODE, ppu_pkg::MODE_4BPP);
    frame_q.push_back(pix_item(1'b0, 16'h00F3));
    wait_drained();

    // clipped line, then zero width
    write_reg(ppu_pkg::CFG_BPP_MODE, ppu_pkg::MODE_1BPP);
    write_reg(ppu_pkg::CFG_LINE_WIDTH, 3);
    frame_q.push_back(pix_item(1'b1, 16'h005A));
    frame_q.push_back(pix_item(1'b0, 16'h00FF));
    frame_q.push_back(pix_item(1'b1, 16'h000F));
    wait_drained();
    write_reg(ppu_pkg::CFG_LINE_WIDTH, 0);
    frame_q.push_back(pix_item(1'b1, 16'h0077));
    wait_drained();

    // unused modes drop data and keep the column
    write_reg(ppu_pkg::CFG_LINE_WIDTH, 240);
    write_reg(ppu_pkg::CFG_BPP_MODE, 5);
    frame_q.push_back(pix_item(1'b1, 16'h1234));
    wait_drained();
    write_reg(ppu_pkg::CFG_BPP_MODE, 7);
    frame_q.push_back(pix_item(1'b0, 16'hBEEF));
    wait_drained();

    for (p = 0; p < 14; p++) begin
      case (p)
        0: begin bpp = ppu_pkg::MODE_RGB565; width = 1;    end
        1: begin bpp = ppu_pkg::MODE_4BPP;   width = 4096; end
        2: begin bpp = ppu_pkg::MODE_8BPP;   width = 8191; end
        3: begin bpp = 6;                    width = 2;    end
        4: begin bpp = ppu_pkg::MODE_1BPP;   width = 4096; end
        default: begin
          bpp = ($urandom_range(15) < 14) ? $urandom_range(4) : $urandom_range(7, 5);
          case ($urandom_range(9))
            0: width = 1;
            1: width = 0;
            2: width = $urandom_range(8, 2);
            3, 4: width = $urandom_range(64, 9);
            5: width = 4096;
            6: width = $urandom_range(8191, 4097);
            default: width = $urandom_range(4095, 65);
          endcase
        end
      endcase
      write_reg(ppu_pkg::CFG_BPP_MODE, bpp);
      write_reg(ppu_pkg::CFG_LINE_WIDTH, width);
      set_idling(p % 4);
      if (p == 4) rx_hold = 250;
      n = (bpp > ppu_pkg::MODE_RGB565) ? 6 : 24;
      for (k = 0; k < n; k++) frame_q.push_back(random_item(k == 0));
      wait_drained();
    end

    if (pixel_q.size() != 0)
      report($sformatf("%0d pixels never arrived", pixel_q.size()));
    $display("Covered %0d input beats and %0d output pixels over %0d register writes,",
             beats_in, pixels_checked, cfg_writes);
    $display("all pixel depths, unused modes, clipped, zero and capped line widths.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/ppu_pkg.sv
src/ppu_ram.sv
src/ppu_seq.sv
src/ppu_out.sv
src/palette_pixel_unpacker.sv
tb/palette_pixel_unpacker_test.sv
